>>> sv/wfps_pkg.sv
// Shared types, constants and the arctangent table for the wall-following steering block.
package wfps_pkg;

   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_ENTRIES = 24;
   localparam int NSTEPS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam int STEP_W = 5;

   localparam int RANGE_W = 15;
   localparam int GAIN_W  = 24;
   localparam int VX_W    = 36;
   localparam int RX_W    = 34;
   localparam int MA_W    = 34;
   localparam int MB_W    = 26;
   localparam int PROD_W  = MA_W + MB_W;
   localparam int ACC_W   = 66;
   localparam int SUM_W   = 40;

   localparam logic [16:0] SIN60_Q16 = 17'd56756;
   localparam logic signed [RX_W-1:0] CORDIC_GAIN_Q30 = 34'sh026DD3B6A;

   localparam logic [8:0] SPEED_FAST   = 9'd384;
   localparam logic [8:0] SPEED_MEDIUM = 9'd256;
   localparam logic [8:0] SPEED_SLOW   = 9'd128;

   localparam logic [GAIN_W-1:0]  RST_GAIN_P    = 24'd36045;
   localparam logic [GAIN_W-1:0]  RST_GAIN_I    = 24'd7;
   localparam logic [GAIN_W-1:0]  RST_GAIN_D    = 24'd13107;
   localparam logic [RANGE_W-1:0] RST_DESIRED   = 15'd563;
   localparam logic [RANGE_W-1:0] RST_LOOKAHEAD = 15'd512;
   localparam logic [RANGE_W-1:0] RST_BAND_FAST = 15'd715;
   localparam logic [RANGE_W-1:0] RST_BAND_MED  = 15'd1430;

   typedef enum logic [2:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_DESIRED   = 3'd3,
      CSR_LOOKAHEAD = 3'd4,
      CSR_BAND_FAST = 3'd5,
      CSR_BAND_MED  = 3'd6
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_VEC, ST_RINIT, ST_ROT, ST_M_BC, ST_M_LS, ST_D, ST_E, ST_SUM,
      ST_M_P, ST_M_IL, ST_M_IH, ST_M_D, ST_K, ST_T, ST_ANG, ST_OUT
   } ctrl_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_VEC, OP_RINIT, OP_ROT, OP_M_BC, OP_M_LS, OP_D, OP_E,
      OP_SUM, OP_M_P, OP_M_IL, OP_M_IH, OP_M_D, OP_K, OP_T, OP_ANG, OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type         op;
      logic [STEP_W-1:0] step;
   } dp_cmd_type;

   // Truncated arctangent of 2^-i in Q30 radians.
   function automatic logic signed [RX_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
      logic signed [RX_W-1:0] r;
      case (idx)
         5'd0:  r = 34'sh03243F6A8;
         5'd1:  r = 34'sh01DAC6705;
         5'd2:  r = 34'sh00FADBAFC;
         5'd3:  r = 34'sh007F56EA6;
         5'd4:  r = 34'sh003FEAB76;
         5'd5:  r = 34'sh001FFD55B;
         5'd6:  r = 34'sh000FFFAAA;
         5'd7:  r = 34'sh0007FFF55;
         5'd8:  r = 34'sh0003FFFEA;
         5'd9:  r = 34'sh0001FFFFD;
         5'd10: r = 34'sh0000FFFFF;
         5'd11: r = 34'sh00007FFFF;
         5'd12: r = 34'sh00003FFFF;
         5'd13: r = 34'sh00001FFFF;
         5'd14: r = 34'sh00000FFFF;
         5'd15: r = 34'sh000007FFF;
         5'd16: r = 34'sh000003FFF;
         5'd17: r = 34'sh000001FFF;
         5'd18: r = 34'sh000000FFF;
         5'd19: r = 34'sh0000007FF;
         5'd20: r = 34'sh0000003FF;
         5'd21: r = 34'sh0000001FF;
         5'd22: r = 34'sh0000000FF;
         5'd23: r = 34'sh00000007F;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

>>> sv/wfps_ctrl.sv
// Controller state machine that sequences the CORDIC, multiply and PID steps.
module wfps_ctrl
   import wfps_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   ctrl_state_type    state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              step_last;
   logic              out_free;

   assign step_last = (step_ff == STEP_W'(NSTEPS - 1));
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_VEC;
         ST_VEC:   if (step_last) state_in = ST_RINIT;
         ST_RINIT: state_in = ST_ROT;
         ST_ROT:   if (step_last) state_in = ST_M_BC;
         ST_M_BC:  state_in = ST_M_LS;
         ST_M_LS:  state_in = ST_D;
         ST_D:     state_in = ST_E;
         ST_E:     state_in = ST_SUM;
         ST_SUM:   state_in = ST_M_P;
         ST_M_P:   state_in = ST_M_IL;
         ST_M_IL:  state_in = ST_M_IH;
         ST_M_IH:  state_in = ST_M_D;
         ST_M_D:   state_in = ST_K;
         ST_K:     state_in = ST_T;
         ST_T:     state_in = ST_ANG;
         ST_ANG:   state_in = ST_OUT;
         ST_OUT:   if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd.op   = OP_NONE;
      cmd.step = step_ff;
      step_in  = '0;
      unique case (state_ff)
         ST_IDLE:  cmd.op = req_valid ? OP_LOAD : OP_NONE;
         ST_VEC: begin
            cmd.op  = OP_VEC;
            step_in = step_last ? '0 : step_ff + 1'b1;
         end
         ST_RINIT: cmd.op = OP_RINIT;
         ST_ROT: begin
            cmd.op  = OP_ROT;
            step_in = step_last ? '0 : step_ff + 1'b1;
         end
         ST_M_BC:  cmd.op = OP_M_BC;
         ST_M_LS:  cmd.op = OP_M_LS;
         ST_D:     cmd.op = OP_D;
         ST_E:     cmd.op = OP_E;
         ST_SUM:   cmd.op = OP_SUM;
         ST_M_P:   cmd.op = OP_M_P;
         ST_M_IL:  cmd.op = OP_M_IL;
         ST_M_IH:  cmd.op = OP_M_IH;
         ST_M_D:   cmd.op = OP_M_D;
         ST_K:     cmd.op = OP_K;
         ST_T:     cmd.op = OP_T;
         ST_ANG:   cmd.op = OP_ANG;
         ST_OUT:   cmd.op = out_free ? OP_OUT : OP_NONE;
         default:  cmd.op = OP_NONE;
      endcase
   end

   always_comb begin
      if (state_ff == ST_OUT && out_free) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> sv/wfps_dp.sv
// Datapath: settings registers, CORDIC units, shared multiplier, PID state and result register.
module wfps_dp
   import wfps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  dp_cmd_type          cmd,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [GAIN_W-1:0]   csr_wdata,
   input  logic [RANGE_W-1:0]  req_range_ahead,
   input  logic                req_range_ahead_ok,
   input  logic [RANGE_W-1:0]  req_range_side,
   input  logic                req_range_side_ok,
   output logic signed [15:0]  rsp_steer_angle,
   output logic [8:0]          rsp_drive_speed,
   output logic signed [15:0]  rsp_distance_error
);

   localparam logic signed [36:0] E_MAX37 = 37'sd32767;
   localparam logic signed [36:0] E_MIN37 = -37'sd32768;
   localparam logic signed [SUM_W:0] S_MAX = 41'sd549755813887;
   localparam logic signed [SUM_W:0] S_MIN = -41'sd549755813888;
   localparam logic signed [ACC_W-1:0] K_LIM = 66'sd4611686018427387904;
   localparam logic signed [ACC_W-1:0] A_MAX = 66'sd32767;
   localparam logic signed [ACC_W-1:0] A_MIN = -66'sd32768;

   logic [GAIN_W-1:0]  gain_p_ff, gain_i_ff, gain_d_ff;
   logic [RANGE_W-1:0] desired_ff, lookahead_ff, band_fast_ff, band_med_ff;

   logic [RANGE_W-1:0] a_eff, b_eff, b_ff;
   logic               zero_ff;
   logic signed [VX_W-1:0] vx_ff, vy_ff;
   logic signed [RX_W-1:0] vz_ff, rx_ff, ry_ff, rz_ff;
   logic signed [VX_W-1:0] vdx, vdy;
   logic signed [RX_W-1:0] rdx, rdy, atan_v;

   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff, ki_ff, prod_x, t_sh, t_neg;

   logic signed [15:0]      e_ff, last_ff, ang_ff;
   logic signed [16:0]      deriv_ff;
   logic signed [SUM_W-1:0] sum_ff;
   logic signed [SUM_W:0]   sum_x;
   logic signed [36:0]      d_val, diff;
   logic [16:0]             mag;

   assign a_eff  = req_range_ahead_ok ? req_range_ahead : '0;
   assign b_eff  = req_range_side_ok ? req_range_side : '0;
   assign vdx    = vy_ff >>> cmd.step;
   assign vdy    = vx_ff >>> cmd.step;
   assign rdx    = ry_ff >>> cmd.step;
   assign rdy    = rx_ff >>> cmd.step;
   assign atan_v = atan_q30(cmd.step);
   assign prod_x = ACC_W'(prod_ff);
   assign d_val  = 37'(acc_ff >>> 30);
   assign diff   = $signed({22'd0, desired_ff}) - d_val;
   assign sum_x  = (SUM_W+1)'(sum_ff) + (SUM_W+1)'(e_ff);
   assign t_sh   = acc_ff >>> 14;
   assign t_neg  = -t_sh;
   assign mag    = ang_ff[15] ? 17'(-$signed({ang_ff[15], ang_ff})) : {1'b0, ang_ff};

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_M_BC: begin mul_a = rx_ff; mul_b = $signed({11'd0, b_ff}); end
         OP_M_LS: begin mul_a = ry_ff; mul_b = $signed({11'd0, lookahead_ff}); end
         OP_M_P:  begin mul_a = MA_W'(e_ff); mul_b = $signed({2'd0, gain_p_ff}); end
         OP_M_IL: begin
            mul_a = $signed({14'd0, sum_ff[19:0]});
            mul_b = $signed({2'd0, gain_i_ff});
         end
         OP_M_IH: begin
            mul_a = MA_W'($signed(sum_ff[SUM_W-1:20]));
            mul_b = $signed({2'd0, gain_i_ff});
         end
         OP_M_D:  begin mul_a = MA_W'(deriv_ff); mul_b = $signed({2'd0, gain_d_ff}); end
         default: begin mul_a = '0; mul_b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= RST_GAIN_P;
         gain_i_ff    <= RST_GAIN_I;
         gain_d_ff    <= RST_GAIN_D;
         desired_ff   <= RST_DESIRED;
         lookahead_ff <= RST_LOOKAHEAD;
         band_fast_ff <= RST_BAND_FAST;
         band_med_ff  <= RST_BAND_MED;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            CSR_DESIRED:   desired_ff   <= csr_wdata[RANGE_W-1:0];
            CSR_LOOKAHEAD: lookahead_ff <= csr_wdata[RANGE_W-1:0];
            CSR_BAND_FAST: band_fast_ff <= csr_wdata[RANGE_W-1:0];
            CSR_BAND_MED:  band_med_ff  <= csr_wdata[RANGE_W-1:0];
            default: ;
         endcase
      end
   end

   // PID state: the error sum and the last error are cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff  <= '0;
         last_ff <= '0;
      end else if (cmd.op == OP_SUM) begin
         if (sum_x > S_MAX) begin
            sum_ff <= S_MAX[SUM_W-1:0];
         end else if (sum_x < S_MIN) begin
            sum_ff <= S_MIN[SUM_W-1:0];
         end else begin
            sum_ff <= sum_x[SUM_W-1:0];
         end
         last_ff <= e_ff;
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            b_ff    <= b_eff;
            zero_ff <= (a_eff == '0) && (b_eff == '0);
            vx_ff   <= $signed(VX_W'({21'd0, a_eff} * {19'd0, SIN60_Q16}));
            vy_ff   <= $signed({6'd0, a_eff, 15'd0}) - $signed({5'd0, b_eff, 16'd0});
            vz_ff   <= '0;
         end
         OP_VEC: begin
            if (!vy_ff[VX_W-1]) begin
               vx_ff <= vx_ff + vdx;
               vy_ff <= vy_ff - vdy;
               vz_ff <= vz_ff + atan_v;
            end else begin
               vx_ff <= vx_ff - vdx;
               vy_ff <= vy_ff + vdy;
               vz_ff <= vz_ff - atan_v;
            end
         end
         OP_RINIT: begin
            rx_ff <= CORDIC_GAIN_Q30;
            ry_ff <= '0;
            rz_ff <= zero_ff ? '0 : vz_ff;
         end
         OP_ROT: begin
            if (!rz_ff[RX_W-1]) begin
               rx_ff <= rx_ff - rdx;
               ry_ff <= ry_ff + rdy;
               rz_ff <= rz_ff - atan_v;
            end else begin
               rx_ff <= rx_ff + rdx;
               ry_ff <= ry_ff - rdy;
               rz_ff <= rz_ff + atan_v;
            end
         end
         OP_M_BC: prod_ff <= mul_a * mul_b;
         OP_M_LS: begin
            prod_ff <= mul_a * mul_b;
            acc_ff  <= prod_x + ACC_W'(67'sd536870912);
         end
         OP_D: acc_ff <= acc_ff + prod_x;
         OP_E: begin
            if (diff > E_MAX37) begin
               e_ff <= 16'sh7FFF;
            end else if (diff < E_MIN37) begin
               e_ff <= 16'sh8000;
            end else begin
               e_ff <= diff[15:0];
            end
         end
         OP_SUM: deriv_ff <= 17'(e_ff) - 17'(last_ff);
         OP_M_P: prod_ff <= mul_a * mul_b;
         OP_M_IL: begin
            prod_ff <= mul_a * mul_b;
            acc_ff  <= prod_x + ACC_W'(67'sd8192);
         end
         OP_M_IH: begin
            prod_ff <= mul_a * mul_b;
            ki_ff   <= prod_x;
         end
         OP_M_D: begin
            prod_ff <= mul_a * mul_b;
            ki_ff   <= ki_ff + (prod_x <<< 20);
         end
         OP_K: begin
            acc_ff <= acc_ff + prod_x;
            if (ki_ff > K_LIM) begin
               ki_ff <= K_LIM;
            end else if (ki_ff < -K_LIM) begin
               ki_ff <= -K_LIM;
            end
         end
         OP_T: acc_ff <= acc_ff + ki_ff;
         OP_ANG: begin
            if (t_neg > A_MAX) begin
               ang_ff <= 16'sh7FFF;
            end else if (t_neg < A_MIN) begin
               ang_ff <= 16'sh8000;
            end else begin
               ang_ff <= t_neg[15:0];
            end
         end
         OP_OUT: begin
            rsp_steer_angle    <= ang_ff;
            rsp_distance_error <= e_ff;
            if (mag <= {2'd0, band_fast_ff}) begin
               rsp_drive_speed <= SPEED_FAST;
            end else if (mag <= {2'd0, band_med_ff}) begin
               rsp_drive_speed <= SPEED_MEDIUM;
            end else begin
               rsp_drive_speed <= SPEED_SLOW;
            end
         end
         default: ;
      endcase
   end

endmodule

>>> sv/wall_follow_pid_steering.sv
// Top level of the wall-following PID steering controller.
//
// Input channel (req_*): one transaction carries the tilted and side beam
// ranges with their valid flags. It is taken when req_valid is high and
// req_stall is low; req_stall is low only while the block is idle.
// Result channel (rsp_*): one transaction per input item carries the
// steering angle, the drive speed and the distance error. It is taken when
// rsp_valid is high and rsp_stall is low; a stalled result holds its value.
// The next item can be accepted in the cycle after the result is loaded. An
// item passes through the vectoring and the rotation CORDIC pass, one step
// per cycle on separate shift-add units, and a sequence of six products
// through the one 34 by 26 bit multiplier.
// The result sits in an output register, so the next item is accepted while
// the previous result still waits; a stalled receiver only holds back the
// load of the following result.
// Reset restores the gain, distance and band registers to their defaults and
// clears the error sum and last error. Settings are written through csr_*,
// always ready; the user must write them only while no item is in flight.
// The block itself does not enforce this.
module wall_follow_pid_steering
   import wfps_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [RANGE_W-1:0]  req_range_ahead,
   input  logic                req_range_ahead_ok,
   input  logic [RANGE_W-1:0]  req_range_side,
   input  logic                req_range_side_ok,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic signed [15:0]  rsp_steer_angle,
   output logic [8:0]          rsp_drive_speed,
   output logic signed [15:0]  rsp_distance_error,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [GAIN_W-1:0]   csr_wdata
);

   dp_cmd_type cmd;

   // Settings registers accept a write in any cycle.
   assign csr_ready = 1'b1;

   wfps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   wfps_dp u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .csr_we             (csr_valid && csr_ready),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_range_ahead    (req_range_ahead),
      .req_range_ahead_ok (req_range_ahead_ok),
      .req_range_side     (req_range_side),
      .req_range_side_ok  (req_range_side_ok),
      .rsp_steer_angle    (rsp_steer_angle),
      .rsp_drive_speed    (rsp_drive_speed),
      .rsp_distance_error (rsp_distance_error)
   );

   // An accepted transaction keeps the input side busy in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input not held off after acceptance");

   // The drive speed is always one of the three bands.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_speed == SPEED_FAST || rsp_drive_speed == SPEED_MEDIUM ||
                     rsp_drive_speed == SPEED_SLOW))
      else $error("drive speed outside the three bands");

   // A new result appears only at the end of an item's work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result raised without an item in flight");

endmodule

>>> verif/wall_follow_pid_steering_tb.sv
// Self-checking testbench for the wall-following PID steering controller.
`timescale 1ns / 100ps

module wall_follow_pid_steering_tb;
   import wfps_pkg::*;

   // Index that maps to no register; a write to it must change nothing.
   localparam logic [2:0] CSR_UNMAPPED = 3'd7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 2 * NSTEPS + 30;
   localparam int RANDOM_PER_PHASE = 110;

   typedef struct packed {
      logic [RANGE_W-1:0] ahead;
      logic               ahead_ok;
      logic [RANGE_W-1:0] side;
      logic               side_ok;
   } scan_type;

   typedef struct packed {
      logic signed [15:0] angle;
      logic [8:0]         speed;
      logic signed [15:0] dist_err;
   } steer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [RANGE_W-1:0] req_range_ahead = '0;
   logic req_range_ahead_ok = 1'b0;
   logic [RANGE_W-1:0] req_range_side = '0;
   logic req_range_side_ok = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [15:0] rsp_steer_angle;
   logic [8:0] rsp_drive_speed;
   logic signed [15:0] rsp_distance_error;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [GAIN_W-1:0] csr_wdata = '0;

   // Shadow copy of the settings and of the PID state.
   longint kp, ki, kd, target_dist, look_dist, band_fast, band_med;
   longint err_integral, prev_err;

   scan_type  scan_q[$];
   steer_type steer_expect_q[$];
   int     fail_count = 0;
   int     scans_sent = 0;
   int     results_checked = 0;
   int     settings_done = 0;
   int     watchdog = 0;
   bit     quiet = 1'b0;

   wall_follow_pid_steering u_top (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   // Works out the steering transaction for one scan and advances the PID state.
   function automatic steer_type steer_predict(scan_type s);
      longint a, b, x, y, z, dx, dy, d, e, deriv, iterm, total, ang, mag;
      steer_type r;
      a = s.ahead_ok ? longint'(s.ahead) : 0;
      b = s.side_ok ? longint'(s.side) : 0;
      z = 0;
      // Vectoring pass finds the wall angle; with both ranges zero it stays zero.
      if (a != 0 || b != 0) begin
         x = a * 56756;
         y = a * 32768 - b * 65536;
         for (int i = 0; i < NSTEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
               x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
            end else begin
               x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
            end
         end
      end
      // Rotation pass turns the angle into cosine and sine.
      x = longint'(CORDIC_GAIN_Q30);
      y = 0;
      for (int i = 0; i < NSTEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= longint'(atan_q30(5'(i)));
         end else begin
            x += dx; y -= dy; z += longint'(atan_q30(5'(i)));
         end
      end
      d = (b * x + look_dist * y + (64'sd1 <<< 29)) >>> 30;
      e = clip(target_dist - d, -32768, 32767);
      err_integral = clip(err_integral + e, -(64'sd1 <<< 39), (64'sd1 <<< 39) - 1);
      deriv = e - prev_err;
      prev_err = e;
      iterm = clip(ki * err_integral, -(64'sd1 <<< 62), 64'sd1 <<< 62);
      total = kp * e + iterm + kd * deriv;
      ang = clip(-((total + 8192) >>> 14), -32768, 32767);
      mag = ang < 0 ? -ang : ang;
      r.angle = 16'(ang);
      r.speed = mag <= band_fast ? SPEED_FAST : (mag <= band_med ? SPEED_MEDIUM : SPEED_SLOW);
      r.dist_err = 16'(e);
      return r;
   endfunction

   // Driver: predicts each accepted scan, then presents the next one or idles.
   always @(posedge clock) begin
      bit taken;
      scan_type nxt;
      taken = req_valid && !req_stall;
      if (taken) begin
         steer_expect_q.push_back(steer_predict({req_range_ahead, req_range_ahead_ok,
                                                 req_range_side, req_range_side_ok}));
         scans_sent++;
      end
      if (!reset && (!req_valid || taken)) begin
         if (scan_q.size() > 0 && (quiet || $urandom_range(0, 99) >= 34)) begin
            nxt = scan_q.pop_front();
            req_valid <= 1'b1;
            req_range_ahead <= nxt.ahead;
            req_range_ahead_ok <= nxt.ahead_ok;
            req_range_side <= nxt.side;
            req_range_side_ok <= nxt.side_ok;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: checks each accepted result against the oldest expectation.
   always @(posedge clock) begin
      steer_type want;
      if (rsp_valid && !rsp_stall) begin
         if (steer_expect_q.size() == 0) begin
            $display("%0t: unexpected result angle=%0d speed=%0d error=%0d", $time,
                     rsp_steer_angle, rsp_drive_speed, rsp_distance_error);
            fail_count++;
         end else begin
            want = steer_expect_q.pop_front();
            results_checked++;
            if (rsp_steer_angle !== want.angle) begin
               $display("%0t: steer_angle expected %0d actual %0d", $time,
                        want.angle, rsp_steer_angle);
               fail_count++;
            end
            if (rsp_drive_speed !== want.speed) begin
               $display("%0t: drive_speed expected %0d actual %0d", $time,
                        want.speed, rsp_drive_speed);
               fail_count++;
            end
            if (rsp_distance_error !== want.dist_err) begin
               $display("%0t: distance_error expected %0d actual %0d", $time,
                        want.dist_err, rsp_distance_error);
               fail_count++;
            end
         end
      end
      rsp_stall <= !quiet && $urandom_range(0, 99) < 34;
   end

   // Watchdog: any transaction on any channel restarts the count.
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)
          || reset) begin
         watchdog <= 0;
      end else if (watchdog >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("Verification failed");
         $finish;
      end else begin
         watchdog <= watchdog + 1;
      end
   end

   task automatic csr_write(input logic [2:0] idx, input logic [GAIN_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_GAIN_P:    kp = val;
         CSR_GAIN_I:    ki = val;
         CSR_GAIN_D:    kd = val;
         CSR_DESIRED:   target_dist = val[RANGE_W-1:0];
         CSR_LOOKAHEAD: look_dist = val[RANGE_W-1:0];
         CSR_BAND_FAST: band_fast = val[RANGE_W-1:0];
         CSR_BAND_MED:  band_med = val[RANGE_W-1:0];
         default: ;
      endcase
      settings_done++;
   endtask

   // Waits until every scan has been accepted and answered, then lets the
   // block settle before the settings change.
   task automatic wait_drained();
      while (scan_q.size() > 0 || req_valid || steer_expect_q.size() > 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic add_scan(input int a, input bit aok, input int s, input bit sok);
      scan_q.push_back({15'(a), aok, 15'(s), sok});
   endtask

   // Mostly plausible wall geometry: the tilted beam sees about twice the side
   // range. The rest is uniform noise and dropped returns.
   task automatic add_random_scans(input int count);
      int side, ahead, mode;
      repeat (count) begin
         mode = $urandom_range(0, 9);
         if (mode < 6) begin
            side = $urandom_range(100, 6000);
            ahead = int'(clip(2 * side + $signed($urandom_range(0, 2000)) - 1000, 0, 32767));
            add_scan(ahead, $urandom_range(0, 19) != 0, side, $urandom_range(0, 19) != 0);
         end else begin
            add_scan(int'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)),
                     int'($urandom_range(0, 32767)), 1'($urandom_range(0, 1)));
         end
      end
   endtask

   task automatic write_all(input logic [GAIN_W-1:0] p, input logic [GAIN_W-1:0] i,
                            input logic [GAIN_W-1:0] dg, input int want, input int look,
                            input int fast, input int med);
      // Bits above a 15-bit register's width are set at random; they must be ignored.
      csr_write(CSR_GAIN_P, p);
      csr_write(CSR_GAIN_I, i);
      csr_write(CSR_GAIN_D, dg);
      csr_write(CSR_DESIRED, {9'($urandom), 15'(want)});
      csr_write(CSR_LOOKAHEAD, {9'($urandom), 15'(look)});
      csr_write(CSR_BAND_FAST, {9'($urandom), 15'(fast)});
      csr_write(CSR_BAND_MED, {9'($urandom), 15'(med)});
   endtask

   initial begin
      kp = RST_GAIN_P; ki = RST_GAIN_I; kd = RST_GAIN_D;
      target_dist = RST_DESIRED; look_dist = RST_LOOKAHEAD;
      band_fast = RST_BAND_FAST; band_med = RST_BAND_MED;
      err_integral = 0; prev_err = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed scans at the reset settings: both ranges zero, a missing
      // tilted return, dropped flags on nonzero ranges and the range extremes.
      add_scan(0, 1, 0, 1);
      add_scan(0, 1, 1000, 1);
      add_scan(0, 0, 32767, 1);
      add_scan(32767, 0, 32767, 0);
      add_scan(32767, 1, 0, 0);
      add_scan(32767, 1, 32767, 1);
      add_scan(1, 1, 1, 1);
      add_scan(32767, 1, 1, 1);
      add_scan(1, 1, 32767, 1);
      add_scan(2000, 1, 1000, 1);
      add_scan(1126, 1, 563, 1);
      add_scan(21845, 1, 10922, 1);
      add_scan(0, 1, 0, 0);
      add_scan(16384, 1, 16383, 1);
      wait_drained();

      // Unmapped index, then every register at its largest value.
      csr_write(CSR_UNMAPPED, 24'hFFFFFF);
      write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 32767, 32767, 32767, 32767);
      add_scan(32767, 1, 32767, 1);
      add_scan(0, 0, 0, 0);
      add_random_scans(40);
      wait_drained();

      // Everything at zero: the steering angle must collapse to zero.
      write_all(24'd0, 24'd0, 24'd0, 0, 0, 0, 0);
      add_scan(0, 1, 32767, 1);
      add_random_scans(40);
      wait_drained();

      // Back to typical gains, first with neither side holding off.
      write_all(RST_GAIN_P, RST_GAIN_I, RST_GAIN_D, 563, 512, 715, 1430);
      quiet = 1'b1;
      add_random_scans(RANDOM_PER_PHASE);
      wait_drained();
      quiet = 1'b0;
      add_random_scans(RANDOM_PER_PHASE);
      wait_drained();

      // Random settings with small bands so that every speed shows up.
      repeat (2) begin
         write_all(24'($urandom_range(0, 24'h0FFFFF)), 24'($urandom_range(0, 255)),
                   24'($urandom_range(0, 24'h03FFFF)), int'($urandom_range(0, 4000)),
                   int'($urandom_range(0, 32767)), int'($urandom_range(0, 2000)),
                   int'($urandom_range(0, 6000)));
         add_random_scans(RANDOM_PER_PHASE);
         wait_drained();
      end

      if (steer_expect_q.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, steer_expect_q.size());
         fail_count++;
      end
      $display("Run covered %0d scans, %0d checked results and %0d register writes.",
               scans_sent, results_checked, settings_done);
      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> files.f
sv/wfps_pkg.sv
sv/wfps_ctrl.sv
sv/wfps_dp.sv
sv/wall_follow_pid_steering.sv
verif/wall_follow_pid_steering_tb.sv
